### rtl/feedback_delay_line_unit_defines.svh
// Assertion macros for the feedback delay line RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef FEEDBACK_DELAY_LINE_UNIT_DEFINES_SVH
`define FEEDBACK_DELAY_LINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FDL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fdl: same-cycle check failed");

// Next-cycle implication.
`define FDL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fdl: next-cycle check failed");

`else

`define FDL_ASSERT_NOW(label, ante, cons)
`define FDL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/fdl_pkg.sv
package fdl_pkg;

	localparam int STORE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int SAMPLE_W = 24;
	localparam int LEN_W    = 17;
	localparam int GAIN_W   = 16;
	localparam int FRAC_W   = 15;

	// Phase must hold the clamped length itself, which may equal the depth.
	localparam int PHASE_W = (ADDR_W + 1 > LEN_W) ? ADDR_W + 1 : LEN_W;

	localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
	localparam int QM_W   = PROD_W - FRAC_W;
	localparam int SUM_W  = QM_W + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = LEN_W;

	localparam logic [GAIN_W-1:0] Q_ONE = GAIN_W'(1 << FRAC_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 3'd0,
		REG_LENGTH   = 3'd1,
		REG_FEEDBACK = 3'd2,
		REG_PRE_POST = 3'd3,
		REG_DRY_WET  = 3'd4
	} reg_idx_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [QM_W-1:0]     qm_t;
	typedef logic signed [SUM_W-1:0]    sum_t;

	// Effective settings, already clamped.
	typedef struct packed {
		logic               pure_mode;
		logic [PHASE_W-1:0] len;
		logic [GAIN_W-1:0]  fb;
		logic [GAIN_W-1:0]  pp;
		logic [GAIN_W-1:0]  dw;
	} cfg_t;

	function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
		return (g > Q_ONE) ? Q_ONE : g;
	endfunction

	// Product scaled down by one in Q1.15, rounded toward minus infinity.
	function automatic qm_t qmul(input sample_t s, input logic [GAIN_W-1:0] g);
		logic signed [PROD_W-1:0] p;
		p = s * $signed({1'b0, g});
		return p[PROD_W-1:FRAC_W];
	endfunction

	function automatic sample_t sat(input sum_t v);
		sample_t r;
		if (v[SUM_W-1:SAMPLE_W-1] == '0 || v[SUM_W-1:SAMPLE_W-1] == '1) begin
			r = v[SAMPLE_W-1:0];
		end else begin
			r = {v[SUM_W-1], {(SAMPLE_W-1){~v[SUM_W-1]}}};
		end
		return r;
	endfunction

endpackage

### rtl/fdl_if.sv
interface fdl_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [fdl_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface fdl_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [fdl_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

### rtl/feedback_delay_line_unit.sv
// Channel   Role      Payload
// in_ch     sink      sample_in  (signed 24 bit)
// out_ch    source    sample_out (signed 24 bit)
// cfg_*     write     cfg_index selects register, cfg_wdata 17 bit
//
// An item goes from acceptance to the output register through a store read, then
// four steps of products and saturating sums; no new item is taken until it is there.
// Pure delay: the store read goes straight to the output register, one item at a time.
// A stall on out_ch holds the sequencer in its last step only while the output
// register is still full. After reset a clearing pass zeroes all 65536 store
// entries, one per cycle, with in_ch.ready low; configuration writes go through.
module feedback_delay_line_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	fdl_in_if.sink                         in_ch,
	fdl_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [fdl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fdl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	fdl_pkg::cfg_t cfg;

	fdl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fdl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

### rtl/fdl_ram.sv
module fdl_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 24,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/fdl_cfg.sv
module fdl_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fdl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fdl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output fdl_pkg::cfg_t                   cfg
);

	logic                          mode_q;
	logic [fdl_pkg::LEN_W-1:0]     length_q;
	logic [fdl_pkg::GAIN_W-1:0]    fb_q;
	logic [fdl_pkg::GAIN_W-1:0]    pp_q;
	logic [fdl_pkg::GAIN_W-1:0]    dw_q;
	logic [fdl_pkg::PHASE_W-1:0]   len_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			length_q <= '0;
			fb_q     <= '0;
			pp_q     <= '0;
			dw_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fdl_pkg::REG_MODE:     mode_q   <= cfg_wdata[0];
				fdl_pkg::REG_LENGTH:   length_q <= cfg_wdata[fdl_pkg::LEN_W-1:0];
				fdl_pkg::REG_FEEDBACK: fb_q     <= cfg_wdata[fdl_pkg::GAIN_W-1:0];
				fdl_pkg::REG_PRE_POST: pp_q     <= cfg_wdata[fdl_pkg::GAIN_W-1:0];
				fdl_pkg::REG_DRY_WET:  dw_q     <= cfg_wdata[fdl_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the length to the store depth; zero acts as one.
	always_comb begin
		len_ext  = fdl_pkg::PHASE_W'(length_q);
		cfg.pure_mode = mode_q;
		if (len_ext > fdl_pkg::PHASE_W'(fdl_pkg::STORE_DEPTH)) begin
			cfg.len = fdl_pkg::PHASE_W'(fdl_pkg::STORE_DEPTH);
		end else if (len_ext == '0) begin
			cfg.len = fdl_pkg::PHASE_W'(1);
		end else begin
			cfg.len = len_ext;
		end
		cfg.fb = fdl_pkg::clamp_gain(fb_q);
		cfg.pp = fdl_pkg::clamp_gain(pp_q);
		cfg.dw = fdl_pkg::clamp_gain(dw_q);
	end

endmodule

### rtl/fdl_core.sv
`include "feedback_delay_line_unit_defines.svh"

module fdl_core (
	input  logic          clk,
	input  logic          arst_n,
	input  fdl_pkg::cfg_t cfg,
	fdl_in_if.sink        in_ch,
	fdl_out_if.source     out_ch
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_MIX  = 6'b000100,
		S_SUM  = 6'b001000,
		S_OUT  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [fdl_pkg::PHASE_W-1:0]   phase_q;
	logic [fdl_pkg::PHASE_W-1:0]   ph_wrap;
	logic                          clear_q;
	logic [fdl_pkg::ADDR_W-1:0]    clr_addr_q;
	logic                          out_valid_q;
	fdl_pkg::sample_t              out_data_q;

	fdl_pkg::sample_t              x_s1;
	logic [fdl_pkg::ADDR_W-1:0]    addr_s1;
	fdl_pkg::sample_t              pre_s2;
	fdl_pkg::sample_t              post_s2;
	fdl_pkg::qm_t                  pa_s3;
	fdl_pkg::qm_t                  pb_s3;
	fdl_pkg::sample_t              mix_s4;
	fdl_pkg::qm_t                  oa_s5;
	fdl_pkg::qm_t                  ob_s5;

	logic                          accept;
	logic                          fin_go;
	fdl_pkg::sample_t              pre;
	fdl_pkg::qm_t                  post_c;
	fdl_pkg::sample_t              store_c;
	fdl_pkg::sample_t              res_c;
	logic [fdl_pkg::GAIN_W-1:0]    pp_inv;
	logic [fdl_pkg::GAIN_W-1:0]    dw_inv;

	logic                          ram_we;
	logic [fdl_pkg::ADDR_W-1:0]    ram_waddr;
	logic [fdl_pkg::SAMPLE_W-1:0]  ram_wdata;
	logic [fdl_pkg::SAMPLE_W-1:0]  ram_rdata;

	always_comb begin
		ph_wrap = (phase_q >= cfg.len) ? '0 : phase_q;
		in_ch.ready = (state_q == S_IDLE) && !clear_q;
		accept = in_ch.valid && in_ch.ready;
		fin_go = !out_valid_q || out_ch.ready;

		pre     = ram_rdata;
		post_c  = fdl_pkg::qmul(pre, cfg.fb);
		pp_inv  = fdl_pkg::GAIN_W'(fdl_pkg::Q_ONE - cfg.pp);
		dw_inv  = fdl_pkg::GAIN_W'(fdl_pkg::Q_ONE - cfg.dw);
		store_c = fdl_pkg::sat(fdl_pkg::SUM_W'(post_s2) + fdl_pkg::SUM_W'(x_s1));
		res_c   = fdl_pkg::sat(fdl_pkg::SUM_W'(oa_s5) + fdl_pkg::SUM_W'(ob_s5));
	end

	// Clearing pass owns the write port until it finishes.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = store_c;
		priority if (clear_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else if (state_q == S_RD && cfg.pure_mode) begin
			ram_we    = 1'b1;
			ram_wdata = x_s1;
		end else if (state_q == S_MIX) begin
			ram_we    = 1'b1;
		end
	end

	fdl_ram #(
		.DEPTH (fdl_pkg::STORE_DEPTH),
		.WIDTH (fdl_pkg::SAMPLE_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (ph_wrap[fdl_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			clear_q     <= 1'b1;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clear_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == fdl_pkg::ADDR_W'(fdl_pkg::STORE_DEPTH - 1)) begin
					clear_q <= 1'b0;
				end
			end

			if (state_q == S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						phase_q <= ph_wrap + 1'b1;
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= cfg.pure_mode ? S_FIN : S_MIX;
				S_MIX: state_q <= S_SUM;
				S_SUM: state_q <= S_OUT;
				S_OUT: state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= in_ch.sample_in;
			addr_s1 <= ph_wrap[fdl_pkg::ADDR_W-1:0];
		end
		if (state_q == S_RD) begin
			pre_s2  <= pre;
			post_s2 <= post_c[fdl_pkg::SAMPLE_W-1:0];
			// Pure delay: pass the stored sample straight to the final sum.
			oa_s5   <= fdl_pkg::QM_W'(pre);
			ob_s5   <= '0;
		end
		if (state_q == S_MIX) begin
			pa_s3 <= fdl_pkg::qmul(pre_s2, pp_inv);
			pb_s3 <= fdl_pkg::qmul(post_s2, cfg.pp);
		end
		if (state_q == S_SUM) begin
			mix_s4 <= fdl_pkg::sat(fdl_pkg::SUM_W'(pa_s3) + fdl_pkg::SUM_W'(pb_s3));
		end
		if (state_q == S_OUT) begin
			oa_s5 <= fdl_pkg::qmul(x_s1, dw_inv);
			ob_s5 <= fdl_pkg::qmul(mix_s4, cfg.dw);
		end
		if (state_q == S_FIN && fin_go) begin
			out_data_q <= res_c;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_data_q;

	`FDL_ASSERT_NOW(a_clear_blocks_input, clear_q, !in_ch.ready)
	`FDL_ASSERT_NEXT(a_accept_starts_read, accept, state_q == S_RD)
	`FDL_ASSERT_NEXT(a_fin_holds_on_stall, state_q == S_FIN && !fin_go,
		state_q == S_FIN && out_valid_q)
	`FDL_ASSERT_NEXT(a_clear_runs_once, !clear_q, !clear_q)

endmodule
